// ===== hw/rtl/tsrp_pkg.sv =====
// Tone sequence recorder/player: shared constants, opcodes, transaction types.
// No dependencies; imported by every module of the block except tsrp_ram.
`default_nettype none

package tsrp_pkg;

    // Store geometry and field widths
    localparam int STORE_DEPTH = 128;
    localparam int FREQ_BITS   = 16;
    localparam int LENGTH_BITS = 16;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [CNT_W-1:0]       CNT_ZERO   = '0;
    localparam logic [CNT_W-1:0]       CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]       CNT_FULL   = CNT_W'(STORE_DEPTH);
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO   = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE    = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX    = '1;
    localparam logic [FREQ_BITS-1:0]   FREQ_ZERO  = '0;

    // Opcodes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_NOTE_START = 3'd1;
    localparam logic [2:0] OP_NOTE_END   = 3'd2;
    localparam logic [2:0] OP_END_REC    = 3'd3;
    localparam logic [2:0] OP_PLAY       = 3'd4;
    localparam logic [2:0] OP_STOP       = 3'd5;
    localparam logic [2:0] OP_ERASE      = 3'd6;

    // Input transaction
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] note_freq;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_freq;
        logic        playing;
        logic        recording;
        logic        store_full;
    } t_out;

    // Accepted item handed to the core
    typedef struct packed {
        logic accept;
        t_in  item;
    } t_core_ctl;

    // 16-bit port field to internal frequency width
    function automatic logic [FREQ_BITS-1:0] freq_from_port(input logic [15:0] x);
        logic [FREQ_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < FREQ_BITS; i++) begin
            if (i < 16) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    // Internal frequency width to 16-bit port field
    function automatic logic [15:0] freq_to_port(input logic [FREQ_BITS-1:0] x);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < FREQ_BITS) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsrp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read (old data on same-address write)
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsrp_core.sv =====
// Recorder/player state update: one accepted item per cycle, entry stores in RAM.
// Depends on tsrp_pkg and tsrp_ram.
`default_nettype none

module tsrp_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tsrp_pkg::t_core_ctl i_ctl,
    output tsrp_pkg::t_out           o_res
);

    import tsrp_pkg::*;

    // State registers
    logic [CNT_W-1:0]       r_count,     n_count;
    logic [CNT_W-1:0]       r_cursor,    n_cursor;
    logic [FREQ_BITS-1:0]   r_open_freq, n_open_freq;
    logic [LENGTH_BITS-1:0] r_elapsed,   n_elapsed;
    logic                   r_note_open, n_note_open;
    logic                   r_rec,       n_rec;
    logic                   r_play,      n_play;
    logic [LENGTH_BITS-1:0] r_left,      n_left;
    logic [FREQ_BITS-1:0]   r_tone,      n_tone;
    logic                   r_ovf,       n_ovf;

    // Copy of entry 0 so that play can start without a read
    logic [FREQ_BITS-1:0]   r_first_freq;
    logic [LENGTH_BITS-1:0] r_first_len;

    // Store write and prefetch read
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [FREQ_BITS-1:0]   wr_freq;
    logic [LENGTH_BITS-1:0] wr_len;
    logic [ADDR_W-1:0]      rd_addr;
    logic [FREQ_BITS-1:0]   ram_freq;
    logic [LENGTH_BITS-1:0] ram_len;
    logic                   r_byp_hit;
    logic [FREQ_BITS-1:0]   r_byp_freq;
    logic [LENGTH_BITS-1:0] r_byp_len;
    logic [FREQ_BITS-1:0]   ent_freq;
    logic [LENGTH_BITS-1:0] ent_len;

    logic                   app;
    logic [FREQ_BITS-1:0]   in_freq;
    logic [FREQ_BITS-1:0]   out_tone;

    tsrp_ram #(.WIDTH(FREQ_BITS), .DEPTH(STORE_DEPTH)) u_freq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_freq),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_freq)
    );

    tsrp_ram #(.WIDTH(LENGTH_BITS), .DEPTH(STORE_DEPTH)) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_len),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_len)
    );

    // Entry at the cursor, with write bypass
    assign ent_freq = r_byp_hit ? r_byp_freq : ram_freq;
    assign ent_len  = r_byp_hit ? r_byp_len  : ram_len;
    assign in_freq  = freq_from_port(i_ctl.item.note_freq);
    assign wr_addr  = r_count[ADDR_W-1:0];
    assign wr_freq  = r_open_freq;
    assign wr_len   = r_elapsed;
    assign rd_addr  = n_cursor[ADDR_W-1:0];

    // Next state for the accepted item
    always_comb begin
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_open_freq = r_open_freq;
        n_elapsed   = r_elapsed;
        n_note_open = r_note_open;
        n_rec       = r_rec;
        n_play      = r_play;
        n_left      = r_left;
        n_tone      = r_tone;
        n_ovf       = r_ovf;
        app         = 1'b0;
        wr_en       = 1'b0;

        if (i_ctl.accept) begin
            unique case (i_ctl.item.opcode)
                OP_TICK: begin
                    if (r_note_open && (r_elapsed != LEN_MAX)) begin
                        n_elapsed = r_elapsed + LEN_ONE;
                    end
                    if (r_play) begin
                        if (r_left <= LEN_ONE) begin
                            if (r_cursor >= r_count) begin
                                n_play   = 1'b0;
                                n_cursor = CNT_ZERO;
                                n_left   = LEN_ZERO;
                                n_tone   = FREQ_ZERO;
                            end else begin
                                n_tone   = ent_freq;
                                n_left   = ent_len;
                                n_cursor = r_cursor + CNT_ONE;
                            end
                        end else begin
                            n_left = r_left - LEN_ONE;
                        end
                    end
                end
                OP_NOTE_START: begin
                    if (!r_rec) begin
                        n_count  = CNT_ZERO;
                        n_ovf    = 1'b0;
                        n_play   = 1'b0;
                        n_cursor = CNT_ZERO;
                        n_left   = LEN_ZERO;
                        n_tone   = FREQ_ZERO;
                    end else if (r_note_open) begin
                        app = 1'b1;
                    end
                    n_rec       = 1'b1;
                    n_note_open = 1'b1;
                    n_open_freq = in_freq;
                    n_elapsed   = LEN_ZERO;
                end
                OP_NOTE_END: begin
                    if (r_note_open) begin
                        app         = 1'b1;
                        n_open_freq = FREQ_ZERO;
                        n_elapsed   = LEN_ZERO;
                    end
                end
                OP_END_REC: begin
                    app         = r_note_open && (r_open_freq != FREQ_ZERO);
                    n_note_open = 1'b0;
                    n_rec       = 1'b0;
                    n_open_freq = FREQ_ZERO;
                    n_elapsed   = LEN_ZERO;
                end
                OP_PLAY: begin
                    if (!r_rec) begin
                        if (r_count == CNT_ZERO) begin
                            n_play   = 1'b0;
                            n_cursor = CNT_ZERO;
                            n_left   = LEN_ZERO;
                            n_tone   = FREQ_ZERO;
                        end else begin
                            n_play   = 1'b1;
                            n_tone   = r_first_freq;
                            n_left   = r_first_len;
                            n_cursor = CNT_ONE;
                        end
                    end
                end
                OP_STOP: begin
                    n_play   = 1'b0;
                    n_cursor = CNT_ZERO;
                    n_left   = LEN_ZERO;
                    n_tone   = FREQ_ZERO;
                end
                OP_ERASE: begin
                    n_count  = CNT_ZERO;
                    n_ovf    = 1'b0;
                    n_play   = 1'b0;
                    n_cursor = CNT_ZERO;
                    n_left   = LEN_ZERO;
                    n_tone   = FREQ_ZERO;
                end
                default: begin
                end
            endcase

            // Append the open note, or flag a full store
            if (app) begin
                if (r_count == CNT_FULL) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_ONE;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_ZERO;
            r_cursor    <= CNT_ZERO;
            r_open_freq <= FREQ_ZERO;
            r_elapsed   <= LEN_ZERO;
            r_note_open <= 1'b0;
            r_rec       <= 1'b0;
            r_play      <= 1'b0;
            r_left      <= LEN_ZERO;
            r_tone      <= FREQ_ZERO;
            r_ovf       <= 1'b0;
            r_byp_hit   <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_open_freq <= n_open_freq;
            r_elapsed   <= n_elapsed;
            r_note_open <= n_note_open;
            r_rec       <= n_rec;
            r_play      <= n_play;
            r_left      <= n_left;
            r_tone      <= n_tone;
            r_ovf       <= n_ovf;
            r_byp_hit   <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Bypass data and entry 0 copy
    always_ff @(posedge i_clk) begin
        r_byp_freq <= wr_freq;
        r_byp_len  <= wr_len;
        if (wr_en && (r_count == CNT_ZERO)) begin
            r_first_freq <= wr_freq;
            r_first_len  <= wr_len;
        end
    end

    // Result from the state after this item
    assign out_tone         = n_play ? n_tone : FREQ_ZERO;
    assign o_res.tone_on    = n_play && (n_tone != FREQ_ZERO);
    assign o_res.tone_freq  = freq_to_port(out_tone);
    assign o_res.playing    = n_play;
    assign o_res.recording  = n_rec;
    assign o_res.store_full = n_ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/tsrp_outbuf.sv =====
// Result register with a skid stage for the output channel.
// Depends on tsrp_pkg.
`default_nettype none

module tsrp_outbuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tsrp_pkg::t_out i_res,
    input  wire logic           i_stall,
    output logic                o_valid,
    output tsrp_pkg::t_out      o_data,
    output logic                o_full
);

    import tsrp_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic take;

    assign take = r_out_valid && !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/tone_sequence_recorder_player_top.sv =====
// Tone sequence recorder/player, top level: core plus output buffer.
// Depends on tsrp_pkg, tsrp_core, tsrp_outbuf.
//
// Records a melody as (frequency, length in ticks) entries and plays it back.
// One transaction is accepted per clock while o_stall is low: each one updates
// the state and gives one result, the status after that transaction.
// Store entries live in RAM with registered read; the entry at the play
// cursor is read ahead every cycle, so a tick that moves to the next entry
// needs no wait. A two-deep output buffer lets input continue while a result
// waits; o_stall rises only when both slots hold results. Store contents are
// not cleared at reset; only entries below the fill count are ever played.
`default_nettype none

module tone_sequence_recorder_player_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tsrp_pkg::t_in  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output tsrp_pkg::t_out      o_data,
    input  wire logic           i_stall
);

    import tsrp_pkg::*;

    t_core_ctl core_ctl;
    t_out      core_res;

    assign core_ctl.accept = i_valid && !o_stall;
    assign core_ctl.item   = i_data;

    tsrp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_res   (core_res)
    );

    tsrp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_ctl.accept),
        .i_res   (core_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_full  (o_stall)
    );

    // Skid slot is only used behind a full output slot
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Playback and recording exclude each other
    a_play_rec_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.playing && o_data.recording))
        else $error("playing while recording");

    // A tone sounds only during playback
    a_tone_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.tone_on) |-> (o_data.playing && (o_data.tone_freq != 16'd0)))
        else $error("tone on outside playback");

    // A full input side drains next cycle when the output is taken
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> !o_stall)
        else $error("skid slot not drained");

endmodule

`default_nettype wire

// ===== tb/tb_tone_sequence_recorder_player_top.sv =====
// Testbench for tone_sequence_recorder_player_top: directed script, then random melody sessions.
// Checks every result against an in-bench melody predictor; depends only on tsrp_pkg and the DUT.
`timescale 1ns / 100ps

module tb_tone_sequence_recorder_player_top;
    import tsrp_pkg::*;

    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          RANDOM_ITEMS = 1050;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [2:0]  OP_UNUSED    = 3'd7;

    localparam t_out QUIET    = '0;
    localparam t_out REC_ONLY = t_out'{1'b0, 16'h0000, 1'b0, 1'b1, 1'b0};

    // One script row: command, how often to repeat it, optional typed-in result
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] freq;
        logic [16:0] reps;
        logic        typed;
        t_out        want;
    } t_script_row;

    localparam int SCRIPT_ROWS = 27;
    t_script_row melody_script [SCRIPT_ROWS] = '{
        // idle block: every command is harmless
        '{OP_TICK,       16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_STOP,       16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_PLAY,       16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_UNUSED,     16'hFFFF, 17'd1,     1'b1, QUIET},
        '{OP_NOTE_END,   16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_END_REC,    16'h0000, 17'd1,     1'b1, QUIET},
        // short melody: loud note, silent note, zero-length notes, trailing silence
        '{OP_NOTE_START, 16'hFFFF, 17'd1,     1'b1, REC_ONLY},
        '{OP_TICK,       16'h0000, 17'd2,     1'b0, QUIET},
        '{OP_NOTE_START, 16'h0000, 17'd1,     1'b0, QUIET},
        '{OP_TICK,       16'h0000, 17'd1,     1'b0, QUIET},
        '{OP_NOTE_END,   16'h0000, 17'd1,     1'b0, QUIET},
        '{OP_NOTE_START, 16'h0001, 17'd1,     1'b0, QUIET},
        '{OP_NOTE_END,   16'h0000, 17'd1,     1'b0, QUIET},
        '{OP_TICK,       16'h0000, 17'd1,     1'b0, QUIET},
        '{OP_END_REC,    16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_PLAY,       16'h0000, 17'd1,     1'b1, t_out'{1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0}},
        '{OP_TICK,       16'h0000, 17'd8,     1'b0, QUIET},
        // new recording, play ignored while recording, erase keeps the open note
        '{OP_NOTE_START, 16'h8000, 17'd1,     1'b1, REC_ONLY},
        '{OP_PLAY,       16'h0000, 17'd1,     1'b1, REC_ONLY},
        '{OP_ERASE,      16'h0000, 17'd1,     1'b1, REC_ONLY},
        // open note keeps counting after the erase
        '{OP_TICK,       16'h0000, 17'd5,     1'b0, QUIET},
        '{OP_END_REC,    16'h0000, 17'd1,     1'b1, QUIET},
        '{OP_PLAY,       16'h0000, 17'd1,     1'b1, t_out'{1'b1, 16'h8000, 1'b1, 1'b0, 1'b0}},
        '{OP_TICK,       16'h0000, 17'd3,     1'b0, QUIET},
        // new recording stops playback; stop while recording
        '{OP_NOTE_START, 16'h5A5A, 17'd1,     1'b1, REC_ONLY},
        '{OP_STOP,       16'h0000, 17'd1,     1'b1, REC_ONLY},
        '{OP_END_REC,    16'h0000, 17'd1,     1'b1, QUIET}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall;

    tone_sequence_recorder_player_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // Melody predictor state
    logic [FREQ_BITS-1:0]   mel_freq [STORE_DEPTH];
    logic [LENGTH_BITS-1:0] mel_len  [STORE_DEPTH];
    int unsigned            mel_count;
    int unsigned            play_pos;
    logic [FREQ_BITS-1:0]   open_freq;
    logic [LENGTH_BITS-1:0] open_ticks;
    logic [LENGTH_BITS-1:0] play_left;
    logic [FREQ_BITS-1:0]   play_tone;
    bit                     note_is_open;
    bit                     rec_active;
    bit                     play_active;
    bit                     full_flag;

    t_out pending_status [$];
    int   mismatches;
    int   cycles;
    int   rand_sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   in_taken;
    logic drv_typed;
    t_out drv_want;

    function automatic void store_note(input logic [FREQ_BITS-1:0] f,
                                       input logic [LENGTH_BITS-1:0] n);
        if (mel_count >= STORE_DEPTH) begin
            full_flag = 1'b1;
        end else begin
            mel_freq[mel_count] = f;
            mel_len[mel_count]  = n;
            mel_count++;
        end
    endfunction

    function automatic void stop_playback();
        play_active = 1'b0;
        play_pos    = 0;
        play_left   = LEN_ZERO;
        play_tone   = FREQ_ZERO;
    endfunction

    function automatic void next_entry();
        if (play_pos >= mel_count) begin
            stop_playback();
        end else begin
            play_tone   = mel_freq[play_pos];
            play_left   = mel_len[play_pos];
            play_pos++;
            play_active = 1'b1;
        end
    endfunction

    // Apply one command to the predicted state; return the status after it
    function automatic t_out melody_step(input t_in it);
        t_out res;
        case (it.opcode)
            OP_TICK: begin
                if (note_is_open && open_ticks != LEN_MAX) open_ticks++;
                if (play_active) begin
                    if (play_left <= LEN_ONE) next_entry();
                    else play_left--;
                end
            end
            OP_NOTE_START: begin
                if (!rec_active) begin
                    mel_count = 0;
                    full_flag = 1'b0;
                    stop_playback();
                end else if (note_is_open) begin
                    store_note(open_freq, open_ticks);
                end
                rec_active   = 1'b1;
                note_is_open = 1'b1;
                open_freq    = it.note_freq;
                open_ticks   = LEN_ZERO;
            end
            OP_NOTE_END: begin
                if (note_is_open) begin
                    store_note(open_freq, open_ticks);
                    open_freq  = FREQ_ZERO;
                    open_ticks = LEN_ZERO;
                end
            end
            OP_END_REC: begin
                // a trailing silence is dropped
                if (note_is_open && open_freq != FREQ_ZERO) store_note(open_freq, open_ticks);
                note_is_open = 1'b0;
                rec_active   = 1'b0;
                open_freq    = FREQ_ZERO;
                open_ticks   = LEN_ZERO;
            end
            OP_PLAY: begin
                if (!rec_active) begin
                    play_pos = 0;
                    next_entry();
                end
            end
            OP_STOP: stop_playback();
            OP_ERASE: begin
                mel_count = 0;
                full_flag = 1'b0;
                stop_playback();
            end
            default: ;
        endcase
        res.tone_on    = play_active && (play_tone != FREQ_ZERO);
        res.tone_freq  = play_active ? play_tone : 16'h0000;
        res.playing    = play_active;
        res.recording  = rec_active;
        res.store_full = full_flag;
        return res;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endfunction

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_tone_sequence_recorder_player_top NOT OK");
            $finish;
        end
    end

    // Receiver side: random stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin : monitor
        t_out want;
        t_out got;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                in_taken = 1'b1;
                want = melody_step(i_data);
                if (drv_typed) want = drv_want;
                pending_status.push_back(want);
            end
            if (o_valid && !i_stall) begin
                got = o_data;
                if (pending_status.size() == 0) begin
                    $error("unexpected result transaction %h", got);
                    mismatches++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("tone_on",    16'(want.tone_on),    16'(got.tone_on));
                    check_field("tone_freq",  want.tone_freq,       got.tone_freq);
                    check_field("playing",    16'(want.playing),    16'(got.playing));
                    check_field("recording",  16'(want.recording),  16'(got.recording));
                    check_field("store_full", 16'(want.store_full), 16'(got.store_full));
                end
            end
        end
    end

    // Drive one transaction and wait until it is taken; returns at a falling edge
    task automatic send_item(input t_in it, input logic typed, input t_out want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_data    <= it;
        drv_typed <= typed;
        drv_want  <= want;
        do @(negedge i_clk); while (!in_taken);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [15:0] f);
        t_in it;
        it.opcode    = op;
        it.note_freq = f;
        send_item(it, 1'b0, QUIET);
        rand_sent++;
    endtask

    function automatic logic [15:0] pick_freq();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One recording session with random content, then a play command and ticks while it plays
    task automatic record_and_play(input int notes, input int max_gap);
        int k;
        for (k = 0; k < notes; k++) begin
            send_op(OP_NOTE_START, pick_freq());
            repeat ($urandom_range(0, max_gap)) send_op(OP_TICK, 16'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                send_op(OP_NOTE_END, 16'($urandom));
                repeat ($urandom_range(0, max_gap)) send_op(OP_TICK, 16'($urandom));
            end
            if ($urandom_range(0, 19) == 0) send_op(3'($urandom_range(0, 7)), 16'($urandom));
        end
        // now and then leave the recording open
        if ($urandom_range(0, 9) != 0) send_op(OP_END_REC, 16'($urandom));
        send_op(OP_PLAY, 16'($urandom));
        k = 0;
        while (play_active && k < 400) begin
            if ($urandom_range(0, 49) == 0) send_op(OP_STOP, 16'($urandom));
            else send_op(OP_TICK, 16'($urandom));
            k++;
        end
    endtask

    // Main sequence
    initial begin
        int r;
        int n;
        int session;
        t_in it;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_stall       = 1'b0;
        drv_typed     = 1'b0;
        drv_want      = QUIET;
        mismatches    = 0;
        cycles        = 0;
        rand_sent     = 0;
        session       = 0;
        send_idle_pct = 14;
        recv_idle_pct = 74;
        mel_count     = 0;
        open_freq     = FREQ_ZERO;
        open_ticks    = LEN_ZERO;
        note_is_open  = 1'b0;
        rec_active    = 1'b0;
        full_flag     = 1'b0;
        stop_playback();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed script
        for (r = 0; r < SCRIPT_ROWS; r++) begin
            it.opcode    = melody_script[r].op;
            it.note_freq = melody_script[r].freq;
            for (n = 0; n < int'(melody_script[r].reps); n++) begin
                send_item(it, melody_script[r].typed, melody_script[r].want);
            end
        end

        // random sessions, idling pattern changes by thirds
        while (rand_sent < RANDOM_ITEMS) begin
            if (rand_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 74;
            end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            session++;
            if (session % 25 == 4) begin
                // overfill the store
                record_and_play(STORE_DEPTH + 4, 0);
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) send_op(3'($urandom_range(0, 7)), 16'($urandom));
            end else begin
                record_and_play($urandom_range(1, 6), 4);
            end
        end
        i_valid <= 1'b0;

        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb_tone_sequence_recorder_player_top OK");
        end else begin
            $display("tb_tone_sequence_recorder_player_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tsrp_pkg.sv
hw/rtl/tsrp_ram.sv
hw/rtl/tsrp_core.sv
hw/rtl/tsrp_outbuf.sv
hw/rtl/tone_sequence_recorder_player_top.sv
tb/tb_tone_sequence_recorder_player_top.sv
